// ===== sv/lbpd_pkg.sv =====
// Shared types, constants and element decode for the low-bit packed dot product.
package lbpd_pkg;

  localparam int unsigned CODE_W  = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ELEM_W  = 8;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INT8  = 2'd0,
    MODE_INT4  = 2'd1,
    MODE_INT2  = 2'd2,
    MODE_SIGN1 = 2'd3
  } mode_t;

  localparam logic [IDX_W-1:0] REG_ACT_MODE    = 1'b0;
  localparam logic [IDX_W-1:0] REG_WEIGHT_MODE = 1'b1;

  typedef struct packed {
    mode_t act_mode;
    mode_t weight_mode;
  } modes_t;

  // Element idx of a packed word; positions past the word read as code zero.
  function automatic logic signed [ELEM_W-1:0] decode_elem(
    input logic [CODE_W-1:0] word,
    input mode_t             mode,
    input int unsigned       idx
  );
    int unsigned          pos;
    logic [CODE_W-1:0]    sh;
    logic [ELEM_W-1:0]    code;
    logic [ELEM_W-1:0]    res;
    pos  = idx * (ELEM_W >> mode);
    sh   = word >> pos;
    code = (pos < CODE_W) ? sh[ELEM_W-1:0] : '0;
    case (mode)
      MODE_INT8:  res = code;
      MODE_INT4:  res = {{4{code[3]}}, code[3:0]};
      MODE_INT2:  res = {{6{code[1]}}, code[1:0]};
      MODE_SIGN1: res = code[0] ? 8'hff : 8'h01;
      default:    res = code;
    endcase
    return signed'(res);
  endfunction

endpackage

// ===== sv/lbpd_group_sum.sv =====
// Per-lane decode and multiply of one group, summed over the active lanes.
module lbpd_group_sum #(
  parameter int unsigned LANES  = 8,
  parameter int unsigned PSUM_W = 20
) (
  input  logic [lbpd_pkg::CODE_W-1:0] act_codes,
  input  logic [lbpd_pkg::CODE_W-1:0] weight_codes,
  input  logic [lbpd_pkg::CNT_W-1:0]  valid_count,
  input  lbpd_pkg::modes_t            modes,
  output logic signed [PSUM_W-1:0]    group_sum
);

  logic signed [lbpd_pkg::PROD_W-1:0] prod [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [lbpd_pkg::ELEM_W-1:0] a_val;
    logic signed [lbpd_pkg::ELEM_W-1:0] w_val;
    logic signed [lbpd_pkg::PROD_W-1:0] lane_prod;
    logic                               lane_on;
    assign a_val     = lbpd_pkg::decode_elem(act_codes, modes.act_mode, i);
    assign w_val     = lbpd_pkg::decode_elem(weight_codes, modes.weight_mode, i);
    // signed multiply at full product width
    assign lane_prod = a_val * w_val;
    // lanes at or beyond LANES never exist, so the count is capped implicitly
    assign lane_on   = (32'(valid_count) > 32'(i));
    assign prod[i]   = lane_on ? lane_prod : '0;
  end

  always_comb begin
    group_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      group_sum = group_sum + PSUM_W'(prod[i]);
    end
  end

endmodule

// ===== sv/low_bit_packed_dot_product.sv =====
// Top level: input register, group multiply-add, running sum and result register.
// A last-group transaction passes through the stage-1 input register and the result register before it shows on out_*.
// Throughput: one group per cycle while in_tready holds; the single group-sum stage sets that figure.
// in_tready drops only while a second result waits behind an untaken one.
// Reset (rst_n, synchronous): clears running sum, modes and all valid flags.
module low_bit_packed_dot_product #(
  parameter int unsigned LANES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // cfg
  input  logic                                cfg_we,
  input  logic [lbpd_pkg::IDX_W-1:0]          cfg_index,
  input  logic [lbpd_pkg::MODE_W-1:0]         cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // act_codes[63:0], weight_codes[127:64], valid_count[131:128], zero pad
  input  logic [lbpd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // dot_sum[31:0]
  output logic [lbpd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned PSUM_W = lbpd_pkg::PROD_W + $clog2(LANES) + 1;

  lbpd_pkg::modes_t                 modes_r;
  logic                             s1_valid_r;
  logic                             s1_valid_nxt;
  logic [lbpd_pkg::CODE_W-1:0]      s1_act_r;
  logic [lbpd_pkg::CODE_W-1:0]      s1_wt_r;
  logic [lbpd_pkg::CNT_W-1:0]       s1_cnt_r;
  logic                             s1_last_r;
  logic [lbpd_pkg::SUM_W-1:0]       acc_r;
  logic [lbpd_pkg::SUM_W-1:0]       acc_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [lbpd_pkg::SUM_W-1:0]       out_data_r;
  logic signed [PSUM_W-1:0]         group_sum;
  logic [lbpd_pkg::SUM_W-1:0]       total;
  logic                             s1_go;
  logic                             in_acc;

  lbpd_group_sum #(
    .LANES  (LANES),
    .PSUM_W (PSUM_W)
  ) u_group_sum (
    .act_codes    (s1_act_r),
    .weight_codes (s1_wt_r),
    .valid_count  (s1_cnt_r),
    .modes        (modes_r),
    .group_sum    (group_sum)
  );

  // stage 1 moves on unless its result would land on an untaken one
  assign s1_go     = s1_valid_r && !(s1_last_r && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign total     = acc_r + lbpd_pkg::SUM_W'(group_sum);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s1_go) begin
      acc_nxt = s1_last_r ? '0 : total;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r     <= '{act_mode: lbpd_pkg::MODE_INT8, weight_mode: lbpd_pkg::MODE_INT8};
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lbpd_pkg::REG_ACT_MODE:    modes_r.act_mode    <= lbpd_pkg::mode_t'(cfg_wdata);
          lbpd_pkg::REG_WEIGHT_MODE: modes_r.weight_mode <= lbpd_pkg::mode_t'(cfg_wdata);
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r  <= in_tdata[63:0];
      s1_wt_r   <= in_tdata[127:64];
      s1_cnt_r  <= in_tdata[131:128];
      s1_last_r <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_data_r <= total;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
